// ----- hw/rtl/cld_pkg.sv -----
package cld_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] CMD_01   = 8'h01;
  localparam logic [7:0] CMD_02   = 8'h02;
  localparam logic [7:0] CMD_10   = 8'h10;
  localparam logic [7:0] CMD_11   = 8'h11;
  localparam logic [7:0] CMD_12   = 8'h12;
  localparam logic [7:0] CMD_13   = 8'h13;
  localparam logic [7:0] CMD_20   = 8'h20;
  localparam logic [7:0] CMD_21   = 8'h21;
  localparam logic [7:0] CMD_CHAT = 8'h80;

  localparam logic [7:0] LEN_1 = 8'h01;
  localparam logic [7:0] LEN_2 = 8'h02;
  localparam logic [7:0] LEN_4 = 8'h04;
  localparam logic [7:0] LEN_5 = 8'h05;

  typedef struct packed {
    logic [7:0] data;
    logic       is_header;
    logic       is_first;
    logic       is_last;
    logic [7:0] command;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic             room;
    logic [QCntW-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic held_valid;
    logic in_payload;
  } frm_stat_t;

  function automatic logic header_ok(input logic [7:0] cmd, input logic [7:0] len);
    logic ok;
    unique case (cmd)
      CMD_01:   ok = (len == LEN_2);
      CMD_02:   ok = (len == LEN_1);
      CMD_10:   ok = (len == LEN_4);
      CMD_11:   ok = (len == LEN_4);
      CMD_12:   ok = (len == LEN_5);
      CMD_13:   ok = (len == LEN_1);
      CMD_20:   ok = (len == LEN_2);
      CMD_21:   ok = (len == LEN_2);
      CMD_CHAT: ok = 1'b1;
      default:  ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ----- hw/rtl/cld_frame.sv -----
module cld_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           data,
  output cld_pkg::push_t       push,
  output cld_pkg::frm_stat_t   stat
);

  logic [7:0] held_r, held_nxt;
  logic       held_v_r, held_v_nxt;
  logic       pay_r, pay_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic       last;

  always_comb begin
    held_nxt   = held_r;
    held_v_nxt = held_v_r;
    pay_nxt    = pay_r;
    rem_nxt    = rem_r;
    cmd_nxt    = cmd_r;
    last       = (rem_r <= 8'd1);
    push       = '0;
    if (step) begin
      if (pay_r) begin
        push.n  = 2'd1;
        push.r0 = '{data: data, is_header: 1'b0, is_first: 1'b0,
                    is_last: last, command: cmd_r};
        rem_nxt = rem_r - 8'd1;
        if (last) begin
          pay_nxt = 1'b0;
          rem_nxt = 8'd0;
        end
      end else if (!held_v_r) begin
        held_nxt   = data;
        held_v_nxt = 1'b1;
      end else if (!cld_pkg::header_ok(held_r, data)) begin
        held_nxt = data;
      end else begin
        push.n  = 2'd2;
        push.r0 = '{data: held_r, is_header: 1'b1, is_first: 1'b1,
                    is_last: 1'b0, command: held_r};
        push.r1 = '{data: data, is_header: 1'b1, is_first: 1'b0,
                    is_last: (data == 8'd0), command: held_r};
        cmd_nxt    = held_r;
        held_v_nxt = 1'b0;
        held_nxt   = 8'd0;
        if (data != 8'd0) begin
          pay_nxt = 1'b1;
          rem_nxt = data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 8'd0;
      held_v_r <= 1'b0;
      pay_r    <= 1'b0;
      rem_r    <= 8'd0;
      cmd_r    <= 8'd0;
    end else begin
      held_r   <= held_nxt;
      held_v_r <= held_v_nxt;
      pay_r    <= pay_nxt;
      rem_r    <= rem_nxt;
      cmd_r    <= cmd_nxt;
    end
  end

  assign stat.held_valid = held_v_r;
  assign stat.in_payload = pay_r;

endmodule

// ----- hw/rtl/cld_outq.sv -----
module cld_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  cld_pkg::push_t   push,
  input  logic             pop,
  output cld_pkg::res_t    head,
  output logic             head_valid,
  output cld_pkg::q_stat_t stat
);

  localparam int Depth = cld_pkg::QDepth;
  localparam int PtrW  = cld_pkg::QPtrW;
  localparam int CntW  = cld_pkg::QCntW;

  cld_pkg::res_t mem [Depth];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign wr_p1 = (wr_r == PtrW'(Depth - 1)) ? '0 : wr_r + PtrW'(1);

  always_comb begin
    wr_nxt = wr_r;
    if (push.n == 2'd1) begin
      wr_nxt = wr_p1;
    end else if (push.n == 2'd2) begin
      wr_nxt = (wr_p1 == PtrW'(Depth - 1)) ? '0 : wr_p1 + PtrW'(1);
    end
    rd_nxt = rd_r;
    if (pop) begin
      rd_nxt = (rd_r == PtrW'(Depth - 1)) ? '0 : rd_r + PtrW'(1);
    end
    cnt_nxt = cnt_r + CntW'(push.n) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head       = mem[rd_r];
  assign head_valid = (cnt_r != '0);
  assign stat.room  = (cnt_r <= CntW'(Depth - 2));
  assign stat.count = cnt_r;

endmodule

// ----- hw/rtl/cmd_length_packet_deframer.sv -----
// Channel  Direction  Ports                                        Handshake
// in       input      in_byte                                      in_valid / in_stall
// out      output     out_byte, out_is_header, out_is_first,       out_valid / out_stall
//                     out_is_last, out_packet_command
//
// One byte is taken every cycle while in_stall is low; it is registered, then framed.
// Its results are written into the result queue and show at the output from there,
// so each byte passes the input register and then the queue before its results leave.
// The four-entry result queue lets a header request push two results at once.
// Synchronous active-low reset returns the framer to hunting with nothing held.
// When out_stall leaves fewer than two free queue entries and a byte is held in the
// input register, in_stall rises and the input register waits.
module cmd_length_packet_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_is_header,
  output logic       out_is_first,
  output logic       out_is_last,
  output logic [7:0] out_packet_command
);

  logic               in_v_r;
  logic [7:0]         in_byte_r;
  logic               step;
  cld_pkg::push_t     push;
  cld_pkg::frm_stat_t frm_stat;
  cld_pkg::q_stat_t   q_stat;
  cld_pkg::res_t      head;
  logic               pop;

  assign step     = in_v_r && q_stat.room;
  assign in_stall = in_v_r && !q_stat.room;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_byte;
    end
  end

  cld_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .data  (in_byte_r),
    .push  (push),
    .stat  (frm_stat)
  );

  cld_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head       (head),
    .head_valid (out_valid),
    .stat       (q_stat)
  );

  assign out_byte           = head.data;
  assign out_is_header      = head.is_header;
  assign out_is_first       = head.is_first;
  assign out_is_last        = head.is_last;
  assign out_packet_command = head.command;

`ifndef ASSERT_OFF
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= ($bits(q_stat.count))'(cld_pkg::QDepth))
    else $error("result queue overflow");

  a_pay_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    frm_stat.in_payload |-> !frm_stat.held_valid)
    else $error("byte held during payload");

  a_hdr_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (push.r0.is_first && push.r1.is_header && !push.r1.is_first))
    else $error("malformed header pair");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (q_stat.count > ($bits(q_stat.count))'(cld_pkg::QDepth - 2)))
    else $error("input stalled with queue room");
`endif

endmodule
